FILE: hdl/vertex_weld_index_remap_top_defines.svh
// Assertion macros shared by the vertex weld block.
// Pulled in by the top level; expects clk_i and rst_ni in scope.
`ifndef VERTEX_WELD_INDEX_REMAP_TOP_DEFINES_SVH
`define VERTEX_WELD_INDEX_REMAP_TOP_DEFINES_SVH

// same-cycle implication
`define VWIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/vwir_pkg.sv
// Shared types, constants and the per-component match test for the vertex weld block.
// No dependencies.
package vwir_pkg;

  localparam int unsigned CAP    = 256;
  localparam int unsigned IDX_W  = $clog2(CAP);
  localparam int unsigned CNT_W  = $clog2(CAP + 1);
  localparam int unsigned COMP_N = 8;
  localparam int unsigned COMP_W = 32;
  localparam int unsigned TOL_W  = 16;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);
  localparam logic             REG_TOL   = 1'b0;  // paddr[2] of the tolerance register

  typedef logic [COMP_N-1:0][COMP_W-1:0] vcomp_t;

  typedef struct packed {
    vcomp_t comp;
    logic   new_group;
  } vertex_t;

  // queue port between front and back
  typedef struct packed {
    logic    valid;
    vertex_t item;
  } vq_head_t;

  // |a - b| < tol, difference at 33 bits so it never wraps
  function automatic logic comp_close(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
                                      logic [TOL_W-1:0] tol);
    logic signed [COMP_W:0] d;
    logic signed [COMP_W:0] t;
    d = signed'({a[COMP_W-1], a}) - signed'({b[COMP_W-1], b});
    t = signed'({{(COMP_W + 1 - TOL_W){1'b0}}, tol});
    return (d < t) && (d > -t);
  endfunction

endpackage

FILE: hdl/vertex_weld_index_remap_top.sv
// Vertex weld / index remap: one result beat per vertex beat.
// Channels: in_valid_i/in_stall_o carry a vertex (eight signed Q16.16
// components plus new_group); out_valid_o/out_stall_i carry remapped_index,
// was_added and table_overflow. A beat moves when valid is high and stall low.
// Vertices enter a two-entry queue; the scanner pulls one at a time and reads
// the unique-vertex memory one entry per cycle through its single read port,
// in insertion order, stopping at the first match.
// The scanner takes one vertex at a time: a queue pop, N memory reads with their
// compares, the result register, then the output register; N is the entries read
// (a match at slot j reads j + 1, a miss all of them, to the 256-entry capacity).
// new_group empties the table before its vertex is handled.
// Reset empties the table and sets match_tolerance to 7; memory contents are
// not cleared, no clearing pass is needed. While out_stall_i is high the result
// holds; the queue keeps accepting until it holds two vertices.
// match_tolerance sits at APB byte address 0; write it only while idle.
// Depends on vwir_pkg, vwir_front, vwir_back and the defines header.
`include "vertex_weld_index_remap_top_defines.svh"
module vertex_weld_index_remap_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vwir_pkg::ADDR_W-1:0]   paddr,
  input  logic [vwir_pkg::DATA_W-1:0]   pwdata,
  output logic [vwir_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            nor_x_i,
  input  logic signed [31:0]            nor_y_i,
  input  logic signed [31:0]            nor_z_i,
  input  logic signed [31:0]            tex_u_i,
  input  logic signed [31:0]            tex_v_i,
  input  logic                          new_group_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    remapped_index_o,
  output logic                          was_added_o,
  output logic                          table_overflow_o
);
  import vwir_pkg::*;

  logic [TOL_W-1:0] tol_q;
  vertex_t          in_item;
  vq_head_t         head;
  logic             pop;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_wr && (paddr[2] == REG_TOL)) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOL) begin
      prdata = {{(DATA_W - TOL_W){1'b0}}, tol_q};
    end
  end

  always_comb begin
    in_item.comp[0]   = pos_x_i;
    in_item.comp[1]   = pos_y_i;
    in_item.comp[2]   = pos_z_i;
    in_item.comp[3]   = nor_x_i;
    in_item.comp[4]   = nor_y_i;
    in_item.comp[5]   = nor_z_i;
    in_item.comp[6]   = tex_u_i;
    in_item.comp[7]   = tex_v_i;
    in_item.new_group = new_group_i;
  end

  vwir_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  vwir_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .tol_i            (tol_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .remapped_index_o (remapped_index_o),
    .was_added_o      (was_added_o),
    .table_overflow_o (table_overflow_o)
  );

  `VWIR_ASSERT_IMP(a_pop_has_item, pop, head.valid, "scanner popped an empty queue")
  `VWIR_ASSERT_IMP(a_flags_exclusive, out_valid_o,
                   !(was_added_o && table_overflow_o), "added and overflow together")
  `VWIR_ASSERT_IMP(a_ovf_index_zero, out_valid_o && table_overflow_o,
                   (remapped_index_o == '0) && !was_added_o,
                   "overflow result with nonzero index")
  `VWIR_ASSERT_NXT(a_no_double_pop, pop, !pop, "two pops in back-to-back cycles")

endmodule

FILE: hdl/vwir_front.sv
// Input side: accepts vertices and holds them in a two-entry queue for the scanner.
// Depends on vwir_pkg.
module vwir_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vwir_pkg::vertex_t in_item_i,
  output vwir_pkg::vq_head_t head_o,
  input  logic              pop_i
);
  import vwir_pkg::*;

  localparam int unsigned QD = 2;

  vertex_t     ent_q [QD];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;

  assign in_stall_o = (cnt_q == 2'(QD));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: hdl/vwir_back.sv
// Scanner (uses vwir_pkg): walks the unique-vertex memory in insertion order,
// appends on a miss (overflow if full) and drives the registered result beat.
module vwir_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vwir_pkg::vq_head_t          head_i,
  output logic                        pop_o,
  input  logic [vwir_pkg::TOL_W-1:0]  tol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [vwir_pkg::IDX_W-1:0]  remapped_index_o,
  output logic                        was_added_o,
  output logic                        table_overflow_o
);
  import vwir_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              out_valid_q, out_valid_d;

  vcomp_t            vtx_q;
  vcomp_t            rd_data_q;
  vcomp_t            vtx_mem [CAP];

  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              res_add_q, res_add_d;
  logic              res_ovf_q, res_ovf_d;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_add_q, out_ovf_q;

  logic              hit;
  logic              mem_re, mem_we;
  logic              out_load;
  logic              slot_free;

  always_comb begin
    hit = 1'b1;
    for (int c = 0; c < COMP_N; c++) begin
      hit = hit & comp_close(vtx_q[c], rd_data_q[c], tol_i);
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_idx_d   = res_idx_q;
    res_add_d   = res_add_q;
    res_ovf_d   = res_ovf_q;
    pop_o       = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          issue_d = '0;
          if (head_i.item.new_group) begin
            cnt_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && hit) begin
          res_idx_d = cmp_idx_q;
          res_add_d = 1'b0;
          res_ovf_d = 1'b0;
          state_d   = ST_RESULT;
        end else if (issue_q < cnt_q) begin
          // one read per cycle; the compare lands in the next cycle
          mem_re    = 1'b1;
          issue_d   = issue_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IDX_W-1:0];
        end else if (cnt_q == CNT_W'(CAP)) begin
          res_idx_d = '0;
          res_add_d = 1'b0;
          res_ovf_d = 1'b1;
          state_d   = ST_RESULT;
        end else begin
          mem_we    = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          res_idx_d = cnt_q[IDX_W-1:0];
          res_add_d = 1'b1;
          res_ovf_d = 1'b0;
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q <= res_idx_d;
    res_add_q <= res_add_d;
    res_ovf_q <= res_ovf_d;
    if (pop_o) begin
      vtx_q <= head_i.item.comp;
    end
    if (out_load) begin
      out_idx_q <= res_idx_q;
      out_add_q <= res_add_q;
      out_ovf_q <= res_ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vtx_mem[cnt_q[IDX_W-1:0]] <= vtx_q;
    end
    if (mem_re) begin
      rd_data_q <= vtx_mem[issue_q[IDX_W-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign remapped_index_o = out_idx_q;
  assign was_added_o      = out_add_q;
  assign table_overflow_o = out_ovf_q;

endmodule
